// File: sv/fbc_pkg.sv
`timescale 1ns / 1ps

package fbc_pkg;

    // Box coordinate width, signed Q12.8 at the default width.
    localparam int COORD_WIDTH = 20;

    // Plane register packing: normal x, y, z (signed Q2.12), then offset (signed Q14.8).
    localparam int NORM_W      = 14;
    localparam int OFF_W       = 22;
    localparam int OFF_LSB     = 3 * NORM_W;
    localparam int CFG_DATA_W  = 64;

    // Offset is shifted left by this to line up with the product fraction bits.
    localparam int FRAC_ALIGN  = 12;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_W     = 3;
    localparam logic [PLANE_W-1:0] NO_PLANE = 3'd6;

    localparam int PROD_W  = COORD_WIDTH + NORM_W;
    localparam int OFFS_W  = OFF_W + FRAC_ALIGN;
    // Three products plus the offset: two growth bits over the wider operand.
    localparam int DIST_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;

    // Classification of a box against one plane or against the whole frustum.
    typedef enum logic [1:0] {
        V_INSIDE  = 2'd0,
        V_CROSS   = 2'd1,
        V_OUTSIDE = 2'd2
    } t_verdict;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] box_min_x;
        logic signed [COORD_WIDTH-1:0] box_min_y;
        logic signed [COORD_WIDTH-1:0] box_min_z;
        logic signed [COORD_WIDTH-1:0] box_max_x;
        logic signed [COORD_WIDTH-1:0] box_max_y;
        logic signed [COORD_WIDTH-1:0] box_max_z;
        logic [PLANE_COUNT-1:0]        inside_mask_in;
        logic [PLANE_W-1:0]            last_out_in;
    } t_in_item;

    typedef struct packed {
        t_verdict               verdict;
        logic [PLANE_COUNT-1:0] inside_mask_out;
        logic [PLANE_W-1:0]     last_out_out;
    } t_out_item;

endpackage

// File: sv/fbc_plane_test.sv
`timescale 1ns / 1ps

// Test one box against one plane: near corner out -> outside,
// far corner out -> crossing, else inside.
module fbc_plane_test (
    input  logic [fbc_pkg::CFG_DATA_W-1:0] i_plane,
    input  fbc_pkg::t_in_item              i_box,
    output fbc_pkg::t_verdict              o_result
);

    logic signed [fbc_pkg::COORD_WIDTH-1:0] box_mn [3];
    logic signed [fbc_pkg::COORD_WIDTH-1:0] box_mx [3];
    logic signed [fbc_pkg::NORM_W-1:0]      nrm    [3];
    logic signed [fbc_pkg::COORD_WIDTH-1:0] c_near [3];
    logic signed [fbc_pkg::COORD_WIDTH-1:0] c_far  [3];
    logic signed [fbc_pkg::PROD_W-1:0]      p_near [3];
    logic signed [fbc_pkg::PROD_W-1:0]      p_far  [3];
    logic signed [fbc_pkg::OFF_W-1:0]       offset;
    logic signed [fbc_pkg::OFFS_W-1:0]      offset_al;
    logic signed [fbc_pkg::DIST_W-1:0]      d_near;
    logic signed [fbc_pkg::DIST_W-1:0]      d_far;
    logic                                   near_out;
    logic                                   far_out;

    assign box_mn[0] = i_box.box_min_x;
    assign box_mn[1] = i_box.box_min_y;
    assign box_mn[2] = i_box.box_min_z;
    assign box_mx[0] = i_box.box_max_x;
    assign box_mx[1] = i_box.box_max_y;
    assign box_mx[2] = i_box.box_max_z;

    assign offset    = signed'(i_plane[fbc_pkg::OFF_LSB +: fbc_pkg::OFF_W]);
    assign offset_al = signed'({offset, {fbc_pkg::FRAC_ALIGN{1'b0}}});

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            nrm[a] = signed'(i_plane[a*fbc_pkg::NORM_W +: fbc_pkg::NORM_W]);
            // Positive normal: near corner takes the minimum; zero counts as not positive.
            if (!nrm[a][fbc_pkg::NORM_W-1] && (nrm[a] != '0)) begin
                c_near[a] = box_mn[a];
                c_far[a]  = box_mx[a];
            end else begin
                c_near[a] = box_mx[a];
                c_far[a]  = box_mn[a];
            end
            p_near[a] = fbc_pkg::PROD_W'(nrm[a]) * fbc_pkg::PROD_W'(c_near[a]);
            p_far[a]  = fbc_pkg::PROD_W'(nrm[a]) * fbc_pkg::PROD_W'(c_far[a]);
        end
    end

    assign d_near = fbc_pkg::DIST_W'(offset_al) + fbc_pkg::DIST_W'(p_near[0])
                  + fbc_pkg::DIST_W'(p_near[1]) + fbc_pkg::DIST_W'(p_near[2]);
    assign d_far  = fbc_pkg::DIST_W'(offset_al) + fbc_pkg::DIST_W'(p_far[0])
                  + fbc_pkg::DIST_W'(p_far[1]) + fbc_pkg::DIST_W'(p_far[2]);

    // Positive distance is outside.
    assign near_out = !d_near[fbc_pkg::DIST_W-1] && (d_near != '0);
    assign far_out  = !d_far[fbc_pkg::DIST_W-1] && (d_far != '0);

    always_comb begin
        if (near_out) begin
            o_result = fbc_pkg::V_OUTSIDE;
        end else if (far_out) begin
            o_result = fbc_pkg::V_CROSS;
        end else begin
            o_result = fbc_pkg::V_INSIDE;
        end
    end

endmodule

// File: sv/frustum_box_classify.sv
`timescale 1ns / 1ps

// Frustum culling of axis-aligned boxes. Each input transaction carries a box
// (signed fixed-point min and max corners) plus its coherency state: a mask of
// planes the box is already known to be fully inside, and the plane that last
// rejected it. The result transaction returns inside, intersecting or outside,
// the updated mask and the rejecting plane (6 for none), ready to be stored back
// with the object. The block takes one transaction per clock unless a stalled
// result holds o_ready low. The box is registered in stage 1, all six planes are
// tested in parallel (one multiplier per axis and corner, then a four-input sum),
// and the coherency priority resolves into the result register. Throughput is
// bounded only by the downstream ready. The six plane registers are written
// through the configuration port; the user must write them only while the block
// is idle, which the block itself does not enforce. Writes to an index above
// five are dropped.
module frustum_box_classify (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fbc_pkg::PLANE_W-1:0]          i_cfg_idx,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  fbc_pkg::t_in_item                    i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output fbc_pkg::t_out_item                   o_data
);

    // ------------------------------------------------------------------
    // Plane registers
    // ------------------------------------------------------------------
    logic [fbc_pkg::CFG_DATA_W-1:0] r_plane [fbc_pkg::PLANE_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++) begin
                r_plane[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++) begin
                if (i_cfg_idx == fbc_pkg::PLANE_W'(i)) begin
                    r_plane[i] <= i_cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: stage 1 holds the box, stage 2 holds the result.
    // Stage 1 advances whenever the result register is empty or drained.
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    fbc_pkg::t_in_item  r_s1_item;
    logic               r_out_valid;
    fbc_pkg::t_out_item r_out_item;
    fbc_pkg::t_out_item n_out_item;
    logic               out_free;
    logic               s1_free;

    assign out_free = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_ready  = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    // Capture the box on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_s1_item <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_item;

    // ------------------------------------------------------------------
    // Per-plane tests, all six in parallel
    // ------------------------------------------------------------------
    fbc_pkg::t_verdict plane_res [fbc_pkg::PLANE_COUNT];

    for (genvar g = 0; g < fbc_pkg::PLANE_COUNT; g++) begin : g_plane
        fbc_plane_test u_test (
            .i_plane  (r_plane[g]),
            .i_box    (r_s1_item),
            .o_result (plane_res[g])
        );
    end

    // ------------------------------------------------------------------
    // Coherency resolution
    // The remembered plane goes first unless masked; an outside there exits
    // with the mask untouched. Then sweep the remaining planes in index
    // order, stopping at the first outside; planes found inside before that
    // stop join the mask.
    // ------------------------------------------------------------------
    logic [fbc_pkg::PLANE_COUNT-1:0] last_sel;
    logic                            last_ok;
    fbc_pkg::t_verdict               last_res;
    logic [fbc_pkg::PLANE_COUNT-1:0] mask_w;
    fbc_pkg::t_verdict               verdict_w;
    logic [fbc_pkg::PLANE_W-1:0]     last_out_w;
    logic                            sweep_done;

    always_comb begin
        last_res = fbc_pkg::V_INSIDE;
        for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++) begin
            // One-hot select of the remembered plane; six and seven select nothing.
            last_sel[i] = (r_s1_item.last_out_in == fbc_pkg::PLANE_W'(i));
            if (last_sel[i]) begin
                last_res = plane_res[i];
            end
        end
        last_ok = |(last_sel & ~r_s1_item.inside_mask_in);

        mask_w     = r_s1_item.inside_mask_in;
        verdict_w  = fbc_pkg::V_INSIDE;
        last_out_w = fbc_pkg::NO_PLANE;
        sweep_done = 1'b0;

        if (last_ok && (last_res == fbc_pkg::V_OUTSIDE)) begin
            verdict_w  = fbc_pkg::V_OUTSIDE;
            last_out_w = r_s1_item.last_out_in;
        end else begin
            if (last_ok) begin
                if (last_res == fbc_pkg::V_CROSS) begin
                    verdict_w = fbc_pkg::V_CROSS;
                end else begin
                    mask_w = mask_w | last_sel;
                end
            end
            for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++) begin
                if (!sweep_done && !mask_w[i] && !last_sel[i]) begin
                    case (plane_res[i])
                        fbc_pkg::V_OUTSIDE: begin
                            verdict_w  = fbc_pkg::V_OUTSIDE;
                            last_out_w = fbc_pkg::PLANE_W'(i);
                            sweep_done = 1'b1;
                        end
                        fbc_pkg::V_CROSS: begin
                            verdict_w = fbc_pkg::V_CROSS;
                        end
                        default: begin
                            mask_w[i] = 1'b1;
                        end
                    endcase
                end
            end
        end

        n_out_item.verdict         = verdict_w;
        n_out_item.inside_mask_out = mask_w;
        n_out_item.last_out_out    = last_out_w;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A rejecting plane is reported exactly when the verdict is outside.
    a_reject_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.verdict == fbc_pkg::V_OUTSIDE) ==
                     (o_data.last_out_out != fbc_pkg::NO_PLANE)))
        else $error("rejecting plane does not match verdict");

    // Inside means every plane is in the mask.
    a_inside_full_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.verdict == fbc_pkg::V_INSIDE)) |->
            (o_data.inside_mask_out == {fbc_pkg::PLANE_COUNT{1'b1}}))
        else $error("inside verdict with incomplete mask");

    // Resolution never clears a mask bit that came in.
    a_mask_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ((r_s1_item.inside_mask_in & ~n_out_item.inside_mask_out) == '0))
        else $error("input mask bit dropped");

    // A stalled box holds in stage 1 until the result register frees.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("stage 1 box lost under stall");

endmodule

// File: tb/frustum_box_classify_checker.sv
`timescale 1ns / 1ps

module frustum_box_classify_checker
    import fbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [PLANE_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_box_valid,
    input  logic                  i_box_ready,
    input  t_in_item              i_box,
    input  logic                  i_cull_valid,
    input  logic                  i_cull_ready,
    input  t_out_item             i_cull,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_classified,
    output int                    o_rejected,
    output int                    o_crossing
);

    localparam int REPORT_LIMIT = 10;

    logic [CFG_DATA_W-1:0] frustum_planes [PLANE_COUNT];
    t_out_item             pending_culls [$];
    t_out_item             want;
    int                    mismatch_count;
    int                    classified;
    int                    rejected;
    int                    crossing;
    int                    reg_idx;

    // Side of one plane the box lies on, from its nearest and farthest corners.
    function automatic t_verdict plane_side(logic [CFG_DATA_W-1:0] plane, t_in_item box);
        longint lo [3];
        longint hi [3];
        longint nrm;
        longint near_dist;
        longint far_dist;
        int     a;
        lo[0] = longint'($signed(box.box_min_x));
        lo[1] = longint'($signed(box.box_min_y));
        lo[2] = longint'($signed(box.box_min_z));
        hi[0] = longint'($signed(box.box_max_x));
        hi[1] = longint'($signed(box.box_max_y));
        hi[2] = longint'($signed(box.box_max_z));
        near_dist = longint'($signed(plane[OFF_LSB +: OFF_W])) <<< FRAC_ALIGN;
        far_dist  = near_dist;
        for (a = 0; a < 3; a++) begin
            nrm = longint'($signed(plane[a * NORM_W +: NORM_W]));
            if (nrm > 0) begin
                near_dist += nrm * lo[a];
                far_dist  += nrm * hi[a];
            end else begin
                near_dist += nrm * hi[a];
                far_dist  += nrm * lo[a];
            end
        end
        if (near_dist > 0) return V_OUTSIDE;
        if (far_dist > 0) return V_CROSS;
        return V_INSIDE;
    endfunction

    // Remembered rejecting plane first, then the sweep over planes not yet known inside.
    function automatic t_out_item predict_cull(t_in_item box);
        t_out_item              res;
        logic [PLANE_COUNT-1:0] mask;
        int                     first;
        int                     k;
        int                     p;
        t_verdict               side;
        res.verdict      = V_INSIDE;
        res.last_out_out = NO_PLANE;
        mask             = box.inside_mask_in;
        first            = -1;
        if (box.last_out_in < PLANE_COUNT && !mask[box.last_out_in])
            first = int'(box.last_out_in);
        for (k = -1; k < PLANE_COUNT; k++) begin
            p = (k < 0) ? first : k;
            if (p < 0) continue;
            if (k >= 0 && p == first) continue;
            if (mask[p]) continue;
            side = plane_side(frustum_planes[p], box);
            if (side == V_OUTSIDE) begin
                res.verdict         = V_OUTSIDE;
                res.last_out_out    = PLANE_W'(p);
                res.inside_mask_out = mask;
                return res;
            end
            if (side == V_CROSS)
                res.verdict = V_CROSS;
            else
                mask[p] = 1'b1;
        end
        res.inside_mask_out = mask;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT)
            $display("cull mismatch: %s", what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (reg_idx = 0; reg_idx < PLANE_COUNT; reg_idx++)
                frustum_planes[reg_idx] = '0;
            pending_culls.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < PLANE_COUNT)
                frustum_planes[i_cfg_idx] = i_cfg_data;
            if (i_box_valid && i_box_ready)
                pending_culls.push_back(predict_cull(i_box));
            if (i_cull_valid && i_cull_ready) begin
                if (pending_culls.size() == 0) begin
                    flag_mismatch($sformatf(
                        "result with no box pending: verdict %0d mask %02h last %0d",
                        i_cull.verdict, i_cull.inside_mask_out, i_cull.last_out_out));
                end else begin
                    want = pending_culls.pop_front();
                    if (i_cull.verdict !== want.verdict
                            || i_cull.inside_mask_out !== want.inside_mask_out
                            || i_cull.last_out_out !== want.last_out_out)
                        flag_mismatch($sformatf(
                            {"result %0d: expected verdict %0d mask %02h last %0d,",
                             " got verdict %0d mask %02h last %0d"},
                            classified, want.verdict, want.inside_mask_out,
                            want.last_out_out, i_cull.verdict,
                            i_cull.inside_mask_out, i_cull.last_out_out));
                    if (want.verdict == V_OUTSIDE) rejected++;
                    if (want.verdict == V_CROSS) crossing++;
                    classified++;
                end
            end
        end
        o_outstanding <= pending_culls.size();
        o_mismatches  <= mismatch_count;
        o_classified  <= classified;
        o_rejected    <= rejected;
        o_crossing    <= crossing;
    end

endmodule

// File: tb/frustum_box_classify_tb.sv
`timescale 1ns / 1ps

module frustum_box_classify_tb;
    import fbc_pkg::*;

    // End the run when this many cycles pass with no transaction of any kind.
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 430;
    // 1.0 in the Q2.12 normal format.
    localparam int UNIT_NORMAL      = 4096;
    localparam int CUBE_HALF        = 100000;
    // A last-out code of seven is an alias for "no plane".
    localparam int LAST_OUT_ALIAS   = 7;
    localparam int COORD_MAX        = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int COORD_MIN        = -(1 << (COORD_WIDTH - 1));
    localparam int NORM_MAX         = (1 << (NORM_W - 1)) - 1;
    localparam int NORM_MIN         = -(1 << (NORM_W - 1));
    localparam int OFF_MAX          = (1 << (OFF_W - 1)) - 1;
    localparam int OFF_MIN          = -(1 << (OFF_W - 1));
    localparam int FULL_MASK        = (1 << PLANE_COUNT) - 1;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [PLANE_W-1:0]    cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  box_valid  = 1'b0;
    logic                  box_ready;
    t_in_item              box_item   = '0;
    logic                  cull_valid;
    logic                  cull_ready = 1'b0;
    t_out_item             cull_result;

    int mismatches;
    int outstanding;
    int classified;
    int rejected;
    int crossing;

    int send_idle_pct;
    int recv_idle_pct;
    int frustum_half;
    int plane_sets;
    int stall_cycles;

    // Values for all eight register indexes; the two above five must be dropped.
    logic [CFG_DATA_W-1:0] plane_set [1 << PLANE_W];

    frustum_box_classify dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (box_valid),
        .o_ready    (box_ready),
        .i_data     (box_item),
        .o_valid    (cull_valid),
        .i_ready    (cull_ready),
        .o_data     (cull_result)
    );

    frustum_box_classify_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_box_valid   (box_valid),
        .i_box_ready   (box_ready),
        .i_box         (box_item),
        .i_cull_valid  (cull_valid),
        .i_cull_ready  (cull_ready),
        .i_cull        (cull_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_classified  (classified),
        .o_rejected    (rejected),
        .o_crossing    (crossing)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result channel at random; the rate follows the current pacing phase.
    always @(posedge clk)
        cull_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Reset the stall count on any transaction, config writes included.
    always @(posedge clk) begin
        if (!rst_n || (box_valid && box_ready) || (cull_valid && cull_ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int jitter(int amp);
        return int'($urandom_range(2 * amp)) - amp;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_plane(int nx, int ny, int nz, int offset);
        return {OFF_W'(offset), NORM_W'(nz), NORM_W'(ny), NORM_W'(nx)};
    endfunction

    // Build an axis-aligned cube frustum of the given half size, each plane tilted a little.
    // Even planes face the positive axis, odd ones the negative.
    task automatic build_frustum(input int half, input int tilt);
        int n [3];
        int p;
        frustum_half = half;
        for (p = 0; p < PLANE_COUNT; p++) begin
            n[0] = jitter(tilt);
            n[1] = jitter(tilt);
            n[2] = jitter(tilt);
            n[p / 2] = (p % 2 == 0) ? UNIT_NORMAL - int'($urandom_range(tilt))
                                    : int'($urandom_range(tilt)) - UNIT_NORMAL;
            plane_set[p] = pack_plane(n[0], n[1], n[2], jitter(16 * tilt) - half);
        end
        plane_set[PLANE_COUNT]     = {$urandom, $urandom};
        plane_set[PLANE_COUNT + 1] = {$urandom, $urandom};
    endtask

    // Write all eight indexes back to back; drop the enable only after the last one.
    task automatic apply_planes();
        int r;
        for (r = 0; r < (1 << PLANE_W); r++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= PLANE_W'(r);
            cfg_data <= plane_set[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        plane_sets++;
    endtask

    // Hold valid and payload until the transaction is taken; idle beforehand at random.
    task automatic send_box(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            box_valid <= 1'b0;
            @(posedge clk);
        end
        box_valid <= 1'b1;
        box_item  <= item;
        @(posedge clk);
        while (!box_ready) @(posedge clk);
    endtask

    task automatic send_directed(input int min_x, input int min_y, input int min_z,
                                 input int max_x, input int max_y, input int max_z,
                                 input int mask, input int last);
        t_in_item item;
        item.box_min_x      = COORD_WIDTH'(min_x);
        item.box_min_y      = COORD_WIDTH'(min_y);
        item.box_min_z      = COORD_WIDTH'(min_z);
        item.box_max_x      = COORD_WIDTH'(max_x);
        item.box_max_y      = COORD_WIDTH'(max_y);
        item.box_max_z      = COORD_WIDTH'(max_z);
        item.inside_mask_in = PLANE_COUNT'(mask);
        item.last_out_in    = PLANE_W'(last);
        send_box(item);
    endtask

    // Mostly boxes around the frustum, some across the whole coordinate range,
    // some with min above max; coherency state is often the plain "nothing known".
    function automatic t_in_item random_box(int half);
        t_in_item b;
        int       c [3];
        int       e [3];
        int       k;
        int       pick;
        pick = $urandom_range(99);
        for (k = 0; k < 3; k++) begin
            c[k] = jitter(2 * half);
            e[k] = $urandom_range(half / 2);
        end
        if (pick < 15) begin
            b.box_min_x = COORD_WIDTH'($urandom);
            b.box_min_y = COORD_WIDTH'($urandom);
            b.box_min_z = COORD_WIDTH'($urandom);
            b.box_max_x = COORD_WIDTH'($urandom);
            b.box_max_y = COORD_WIDTH'($urandom);
            b.box_max_z = COORD_WIDTH'($urandom);
        end else if (pick < 22) begin
            b.box_min_x = COORD_WIDTH'(c[0] + e[0]);
            b.box_min_y = COORD_WIDTH'(c[1] + e[1]);
            b.box_min_z = COORD_WIDTH'(c[2] + e[2]);
            b.box_max_x = COORD_WIDTH'(c[0] - e[0]);
            b.box_max_y = COORD_WIDTH'(c[1] - e[1]);
            b.box_max_z = COORD_WIDTH'(c[2] - e[2]);
        end else begin
            b.box_min_x = COORD_WIDTH'(c[0] - e[0]);
            b.box_min_y = COORD_WIDTH'(c[1] - e[1]);
            b.box_min_z = COORD_WIDTH'(c[2] - e[2]);
            b.box_max_x = COORD_WIDTH'(c[0] + e[0]);
            b.box_max_y = COORD_WIDTH'(c[1] + e[1]);
            b.box_max_z = COORD_WIDTH'(c[2] + e[2]);
        end
        b.inside_mask_in = ($urandom_range(99) < 45) ? '0 : PLANE_COUNT'($urandom_range(FULL_MASK));
        b.last_out_in    = ($urandom_range(99) < 45) ? NO_PLANE
                                                     : PLANE_W'($urandom_range(LAST_OUT_ALIAS));
        return b;
    endfunction

    // Pause the sender until every expected result has come back.
    task automatic wait_drained();
        box_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_PER_PHASE) send_box(random_box(frustum_half));
        wait_drained();
    endtask

    initial begin
        send_idle_pct = 34;
        recv_idle_pct = 67;
        plane_sets    = 0;
        frustum_half  = CUBE_HALF;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Planes still at reset: every distance is zero, so every box is inside.
        send_directed(0, 0, 0, 0, 0, 0, 0, NO_PLANE);
        send_directed(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                      0, LAST_OUT_ALIAS);
        wait_drained();

        // Extreme plane registers: full-scale normals and offsets, all ones, all zeros.
        plane_set[0] = pack_plane(NORM_MAX, NORM_MIN, 0, 0);
        plane_set[1] = '1;
        plane_set[2] = pack_plane(NORM_MIN, NORM_MAX, NORM_MIN, OFF_MIN);
        plane_set[3] = pack_plane(0, 0, 0, OFF_MIN);
        plane_set[4] = pack_plane(NORM_MAX, NORM_MAX, NORM_MAX, OFF_MAX);
        plane_set[5] = '0;
        plane_set[6] = '1;
        plane_set[7] = {$urandom, $urandom};
        apply_planes();
        send_directed(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                      0, NO_PLANE);
        send_directed(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                      0, 0);
        send_directed(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                      6'h15, 3);
        send_directed(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                      6'h2a, LAST_OUT_ALIAS);
        wait_drained();

        // Exact cube frustum: normals on the axes, zero components elsewhere.
        build_frustum(CUBE_HALF, 0);
        apply_planes();
        // well inside every plane
        send_directed(-1000, -1000, -1000, 1000, 1000, 1000, 0, NO_PLANE);
        // straddles the right plane
        send_directed(90000, -10, -10, 110000, 10, 10, 0, NO_PLANE);
        // beyond the right plane, caught first in the sweep
        send_directed(150000, -10, -10, 160000, 10, 10, 0, NO_PLANE);
        // beyond the far plane, rejected by the remembered plane
        send_directed(-10, -10, -160000, 10, 10, -150000, 0, 5);
        // same box, last-out alias: sweep marks five planes inside first
        send_directed(-10, -10, -160000, 10, 10, -150000, 0, LAST_OUT_ALIAS);
        // remembered plane already in the mask: skipped everywhere
        send_directed(-10, -10, -160000, 10, 10, -150000, 6'h20, 5);
        // touching the right plane counts as inside, one step past crosses
        send_directed(0, 0, 0, CUBE_HALF, 0, 0, 0, NO_PLANE);
        send_directed(0, 0, 0, CUBE_HALF + 1, 0, 0, 0, NO_PLANE);
        // min above max, corners taken as given
        send_directed(50000, 10, 10, -50000, -10, -10, 0, NO_PLANE);
        send_directed(150000, 10, 10, -150000, -10, -10, 0, 1);
        // everything already known inside
        send_directed(150000, -10, -10, 160000, 10, 10, FULL_MASK, 0);
        // box larger than the frustum crosses every plane
        send_directed(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                      0, NO_PLANE);
        // remembered plane only crossed, then the sweep continues
        send_directed(-10, 90000, -10, 10, 110000, 10, 6'h01, 2);
        wait_drained();

        // Random boxes through three pacing phases, a fresh frustum for each.
        build_frustum(CUBE_HALF, 800);
        apply_planes();
        random_phase(34, 67);

        build_frustum(60000, 3000);
        apply_planes();
        random_phase(67, 34);

        build_frustum(150000, 200);
        apply_planes();
        random_phase(0, 0);

        // Let the pipeline settle so a stray extra result would show.
        repeat (8) @(posedge clk);

        $display("classified %0d boxes (%0d outside, %0d crossing) over %0d plane sets,",
                 classified, rejected, crossing, plane_sets);
        $display("with sender and receiver stalls swapped between phases and one unstalled phase");
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
